@@ rtl/sbr_pkg.sv @@
// ============================================================================
// sbr_pkg
// Shared types, codes and constants of the system bus with reservations.
// ============================================================================
package sbr_pkg;

	// Fixed geometry of the address map.
	localparam int VIDEO_WORDS    = 4096;
	localparam int MAIN_WORD_BITS = 25;   // word index bits below the main memory limit
	localparam int CFG_IDX_W      = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BP_ADDR0 = 3'd1;

	// Device codes reported with every result.
	localparam logic [2:0] DEV_MAIN  = 3'd0;
	localparam logic [2:0] DEV_VIDEO = 3'd1;
	localparam logic [2:0] DEV_KEYBD = 3'd2;
	localparam logic [2:0] DEV_PIC   = 3'd3;
	localparam logic [2:0] DEV_LEDS  = 3'd4;
	localparam logic [2:0] DEV_NONE  = 3'd5;

	// Multiply-with-carry generator constants.
	localparam logic [31:0] GEN_Z_INIT = 32'd88888888;
	localparam logic [31:0] GEN_W_INIT = 32'd12345678;
	localparam logic [15:0] GEN_Z_MUL  = 16'd36969;
	localparam logic [15:0] GEN_W_MUL  = 16'd18000;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_RESV  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_COND  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] addr;
		logic [31:0] data;
		logic [3:0]  lanes;
	} req_t;

	typedef struct packed {
		logic [31:0] rd;
		logic        done;
		logic        fault;
		logic [2:0]  dev;
		logic        hit;
		logic        stop;
		logic        err;
		logic [31:0] led;
		logic        scr;
	} res_t;

	function automatic bit sbr_is_pow2(int unsigned n);
		return (n & (n - 1)) == 0;
	endfunction

	// Cycles the main memory index needs after the address is presented.
	function automatic int sbr_idx_lat(int unsigned n);
		return sbr_is_pow2(n) ? 0 : 2;
	endfunction

endpackage

@@ rtl/system_bus_with_reservations.sv @@
// ============================================================================
// system_bus_with_reservations
// Emulated system bus with main and video memory, LED latch, device decode,
// two load reservations and data breakpoints.
// ============================================================================
//
// Channel     Direction  Handshake              Payload
// ----------  ---------  ---------------------  ---------------------------------
// input       in         in_valid / in_ready    command, address, write_data,
//                                               byte_lanes
// output      out        out_valid / out_ready  read_data, write_done,
//                                               protect_fault, device,
//                                               breakpoint_hit, stopped,
//                                               error_flag, led_value,
//                                               refresh_pending
// config      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each access passes through the registered read of the memories and then a
// step that merges, writes back and registers the result; when MAIN_WORDS is
// not a power of two, the registered reciprocal index calculation comes first.
// After reset the block clears both memories, one word a cycle; the input
// channel is not ready meanwhile, while configuration transfers are taken
// at any time.
// A new input transfer is taken while a result waits on the output; that
// access then holds in its final cycle until the output register frees up.
//
module system_bus_with_reservations #(
	parameter int MAIN_WORDS      = 65536,
	parameter int MAX_BREAKPOINTS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [31:0]                    address,
	input  logic [31:0]                    write_data,
	input  logic [3:0]                     byte_lanes,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    read_data,
	output logic                           write_done,
	output logic                           protect_fault,
	output logic [2:0]                     device,
	output logic                           breakpoint_hit,
	output logic                           stopped,
	output logic                           error_flag,
	output logic [31:0]                    led_value,
	output logic                           refresh_pending,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import sbr_pkg::*;

	localparam int AW      = $clog2(MAIN_WORDS);
	localparam int VW      = $clog2(VIDEO_WORDS);
	localparam int IDX_LAT = sbr_idx_lat(MAIN_WORDS);
	localparam int CLR_LEN = (MAIN_WORDS > VIDEO_WORDS) ? MAIN_WORDS : VIDEO_WORDS;
	localparam int CW      = $clog2(CLR_LEN);

	// Address map.
	localparam logic [31:0] MAIN_LIMIT = 32'd134217728;
	localparam logic [31:0] LEDS_BASE  = 32'hFFDC0600;
	localparam logic [31:0] VIDEO_BASE = 32'hFFD00000;
	localparam logic [31:0] KEYBD_BASE = 32'hFFDC0000;
	localparam logic [31:0] PIC_BASE   = 32'hFFDC0FC0;
	localparam logic [15:0] PROT_PAGE  = 16'h0001;   // 0x10000 to 0x1FFFF

	// Byte-lane patterns that modify main memory.
	localparam logic [3:0] LANES_WORD = 4'hF;
	localparam logic [3:0] LANES_B0   = 4'h1;
	localparam logic [3:0] LANES_B1   = 4'h2;
	localparam logic [3:0] LANES_B2   = 4'h4;
	localparam logic [3:0] LANES_B3   = 4'h8;
	localparam logic [3:0] LANES_H0   = 4'h3;
	localparam logic [3:0] LANES_HM   = 4'h6;
	localparam logic [3:0] LANES_H1   = 4'hC;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_EXEC
	} state_t;

	function automatic logic [2:0] decode(input logic [31:0] a);
		logic [2:0] dev;
		priority if (a < MAIN_LIMIT)                          dev = DEV_MAIN;
		else if ((a & 32'hFFFFFF00) == LEDS_BASE)             dev = DEV_LEDS;
		else if ((a & 32'hFFFF0000) == VIDEO_BASE)            dev = DEV_VIDEO;
		else if ((a & 32'hFFFFFFF0) == KEYBD_BASE)            dev = DEV_KEYBD;
		else if ((a & 32'hFFFFFFC0) == PIC_BASE)              dev = DEV_PIC;
		else                                                  dev = DEV_NONE;
		return dev;
	endfunction

	// Returns {modifies, merged word}; other lane patterns leave the word alone.
	function automatic logic [32:0] merge(input logic [31:0] old, input logic [31:0] d,
	                                      input logic [3:0] lanes);
		logic [32:0] m;
		unique case (lanes)
			LANES_WORD: m = {1'b1, d};
			LANES_B0:   m = {1'b1, old[31:8], d[7:0]};
			LANES_B1:   m = {1'b1, old[31:16], d[7:0], old[7:0]};
			LANES_B2:   m = {1'b1, old[31:24], d[7:0], old[15:0]};
			LANES_B3:   m = {1'b1, d[7:0], old[23:0]};
			LANES_H0:   m = {1'b1, old[31:16], d[15:0]};
			LANES_HM:   m = {1'b1, old[31:24], d[15:0], old[7:0]};
			LANES_H1:   m = {1'b1, d[15:0], old[15:0]};
			default:    m = {1'b0, old};
		endcase
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Control and state registers
	// ------------------------------------------------------------------
	state_t          state_q;
	logic [1:0]      cnt_q;
	logic [CW-1:0]   clr_q;
	logic            out_valid_q;
	res_t            res_q;

	req_t            req_q;
	logic [AW-1:0]   midx_q;

	logic [31:0]     resa_q, resb_q;
	logic [31:0]     genz_q, genw_q;
	logic            err_q, stop_q, scr_q;
	logic [31:0]     led_q;
	logic [2:0]      bpcnt_q;
	logic [31:0]     bp_q [MAX_BREAKPOINTS];

	// ------------------------------------------------------------------
	// Handshakes and sequencing
	// ------------------------------------------------------------------
	logic            accept;
	logic            issue;
	logic            fire;
	logic            clearing;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign clearing  = (state_q == ST_CLEAR);

	// The memory read goes out on the accepting edge when the index is a
	// plain mask, otherwise once the index pipeline has produced it.
	assign issue = (accept && (IDX_LAT == 0)) || ((state_q == ST_INDEX) && (cnt_q == 2'd0));

	// The access completes only when the output register can take the result.
	// Its memory write lands on that same edge, and the next read can only be
	// issued on a later edge, so accesses to one word never overlap.
	assign fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// ------------------------------------------------------------------
	// Index and memories
	// ------------------------------------------------------------------
	logic [31:0]     src_addr;
	logic [AW-1:0]   main_idx;
	logic [31:0]     main_rd;
	logic [32:0]     vid_rd;      // bit 32 is the dirty bit of the word
	logic            main_we, vid_we;
	logic [AW-1:0]   main_waddr;
	logic [31:0]     main_wdata;
	logic [VW-1:0]   vid_waddr;
	logic [32:0]     vid_wdata;
	logic            clr_main, clr_vid;

	logic [32:0]     merged;
	logic            main_wr, vid_wr, led_wr;

	assign src_addr = (state_q == ST_IDLE) ? address : req_q.addr;

	sbr_index #(
		.MAIN_WORDS (MAIN_WORDS)
	) u_index (
		.clk  (clk),
		.word (src_addr[MAIN_WORD_BITS+1:2]),
		.idx  (main_idx)
	);

	assign clr_main = clearing && ({1'b0, clr_q} < (CW+1)'(MAIN_WORDS));
	assign clr_vid  = clearing && ({1'b0, clr_q} < (CW+1)'(VIDEO_WORDS));

	assign main_we    = clr_main || (fire && main_wr);
	assign main_waddr = clearing ? clr_q[AW-1:0] : midx_q;
	assign main_wdata = clearing ? 32'd0 : merged[31:0];

	// Video words reset to zero with the dirty bit set; a write sets it again.
	assign vid_we    = clr_vid || (fire && vid_wr);
	assign vid_waddr = clearing ? clr_q[VW-1:0] : req_q.addr[VW+1:2];
	assign vid_wdata = clearing ? {1'b1, 32'd0} : {1'b1, req_q.data};

	sbr_ram #(
		.WIDTH (32),
		.DEPTH (MAIN_WORDS)
	) u_main_ram (
		.clk   (clk),
		.we    (main_we),
		.waddr (main_waddr),
		.wdata (main_wdata),
		.re    (issue),
		.raddr (main_idx),
		.rdata (main_rd)
	);

	sbr_ram #(
		.WIDTH (33),
		.DEPTH (VIDEO_WORDS)
	) u_video_ram (
		.clk   (clk),
		.we    (vid_we),
		.waddr (vid_waddr),
		.wdata (vid_wdata),
		.re    (issue),
		.raddr (src_addr[VW+1:2]),
		.rdata (vid_rd)
	);

	// ------------------------------------------------------------------
	// Access execution
	// ------------------------------------------------------------------
	logic [2:0]      dev;
	logic            is_wr;
	logic            go;
	logic            prot;
	logic [31:0]     gz_n, gw_n;
	logic [31:0]     nx_resa, nx_resb, nx_genz, nx_genw;
	logic [2:0]      bp_lim;
	logic            bp_match;
	res_t            res_d;

	assign dev   = decode(req_q.addr);
	assign is_wr = (req_q.cmd == CMD_WRITE) || (req_q.cmd == CMD_COND);
	assign prot  = (req_q.addr[31:16] == PROT_PAGE);

	// Next generator values; only used when both reservations are taken.
	assign gz_n = {16'd0, genz_q[15:0]} * {16'd0, GEN_Z_MUL} + {16'd0, genz_q[31:16]};
	assign gw_n = {16'd0, genw_q[15:0]} * {16'd0, GEN_W_MUL} + {16'd0, genw_q[31:16]};

	assign merged = merge(main_rd, req_q.data, req_q.lanes);

	always_comb begin
		nx_resa = resa_q;
		nx_resb = resb_q;
		nx_genz = genz_q;
		nx_genw = genw_q;
		go      = 1'b1;

		if (req_q.cmd == CMD_RESV) begin
			// A reservation holding zero counts as an empty slot.
			if (resa_q == 32'd0) begin
				nx_resa = req_q.addr;
			end else if (resb_q == 32'd0) begin
				nx_resb = req_q.addr;
			end else begin
				nx_genz = gz_n;
				nx_genw = gw_n;
				// Low bit of (z << 16) + w is the low bit of w.
				if (gw_n[0]) begin
					nx_resb = req_q.addr;
				end else begin
					nx_resa = req_q.addr;
				end
			end
		end

		if (req_q.cmd == CMD_COND) begin
			if ((req_q.addr != resa_q) && (req_q.addr != resb_q)) begin
				go = 1'b0;
			end else begin
				if (req_q.addr == resa_q) begin
					nx_resa = 32'd0;
				end
				if (req_q.addr == resb_q) begin
					nx_resb = 32'd0;
				end
			end
		end
	end

	assign main_wr = is_wr && go && (dev == DEV_MAIN) && !prot && merged[32];
	assign vid_wr  = is_wr && go && (dev == DEV_VIDEO);
	assign led_wr  = is_wr && go && (dev == DEV_LEDS);

	// Breakpoint compare over the active entries; a count beyond the
	// implemented entries means all of them.
	assign bp_lim = (bpcnt_q > 3'(MAX_BREAKPOINTS)) ? 3'(MAX_BREAKPOINTS) : bpcnt_q;

	always_comb begin
		bp_match = 1'b0;
		for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
			if ((3'(i) < bp_lim) && (req_q.addr == bp_q[i])) begin
				bp_match = 1'b1;
			end
		end
	end

	always_comb begin
		res_d       = '0;
		res_d.done  = go;
		res_d.fault = is_wr && go && (dev == DEV_MAIN) && prot;
		res_d.dev   = dev;
		res_d.hit   = is_wr && bp_match;
		res_d.stop  = stop_q || res_d.hit;
		res_d.err   = err_q || res_d.fault;
		res_d.led   = led_wr ? req_q.data : led_q;
		res_d.scr   = scr_q || vid_wr;
		if (!is_wr) begin
			if (dev == DEV_MAIN) begin
				res_d.rd = main_rd;
			end else if (dev == DEV_VIDEO) begin
				res_d.rd = vid_rd[31:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= 2'd0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_LEN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (IDX_LAT == 0) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_INDEX;
							cnt_q   <= 2'(IDX_LAT - 1);
						end
					end
				end
				ST_INDEX: begin
					if (cnt_q == 2'd0) begin
						state_q <= ST_EXEC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
			endcase

			if (fire) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and index capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.cmd   <= cmd_t'(command);
			req_q.addr  <= address;
			req_q.data  <= write_data;
			req_q.lanes <= byte_lanes;
		end
		if (issue) begin
			midx_q <= main_idx;
		end
	end

	// Architectural state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resa_q  <= 32'd0;
			resb_q  <= 32'd0;
			genz_q  <= GEN_Z_INIT;
			genw_q  <= GEN_W_INIT;
			err_q   <= 1'b0;
			stop_q  <= 1'b0;
			scr_q   <= 1'b1;
			led_q   <= 32'd0;
			bpcnt_q <= 3'd0;
			for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
				bp_q[i] <= 32'd0;
			end
		end else begin
			if (fire) begin
				resa_q <= nx_resa;
				resb_q <= nx_resb;
				genz_q <= nx_genz;
				genw_q <= nx_genw;
				err_q  <= res_d.err;
				stop_q <= res_d.stop;
				scr_q  <= res_d.scr;
				led_q  <= res_d.led;
			end
			if (cfg_valid) begin
				if (cfg_index == REG_BP_COUNT) begin
					bpcnt_q <= cfg_data[2:0];
				end
				for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
					if (cfg_index == CFG_IDX_W'(REG_BP_ADDR0 + i)) begin
						bp_q[i] <= cfg_data;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Outputs
	// ------------------------------------------------------------------
	assign out_valid       = out_valid_q;
	assign read_data       = res_q.rd;
	assign write_done      = res_q.done;
	assign protect_fault   = res_q.fault;
	assign device          = res_q.dev;
	assign breakpoint_hit  = res_q.hit;
	assign stopped         = res_q.stop;
	assign error_flag      = res_q.err;
	assign led_value       = res_q.led;
	assign refresh_pending = res_q.scr;

endmodule

@@ rtl/sbr_ram.sv @@
// ============================================================================
// sbr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module sbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/sbr_index.sv @@
// ============================================================================
// sbr_index
// Main memory word index: the word address wrapped to the memory size.
// ============================================================================
module sbr_index #(
	parameter int MAIN_WORDS = 65536
) (
	input  logic                              clk,
	input  logic [sbr_pkg::MAIN_WORD_BITS-1:0] word,
	output logic [$clog2(MAIN_WORDS)-1:0]      idx
);
	import sbr_pkg::*;

	localparam int AW = $clog2(MAIN_WORDS);
	localparam int XW = MAIN_WORD_BITS;

	generate
		if (sbr_is_pow2(MAIN_WORDS)) begin : g_mask
			// A power-of-two size wraps by dropping the upper bits.
			assign idx = word[AW-1:0];
		end else begin : g_recip
			// Quotient estimate by reciprocal multiplication. The estimate is
			// at most one low, so one compare and subtract finishes the job.
			localparam int unsigned RECIP = (2 ** XW) / MAIN_WORDS;
			localparam int RW = $clog2(RECIP + 1);
			localparam int MW = $clog2(MAIN_WORDS + 1);

			logic [XW-1:0]    x_s1;
			logic [XW+RW-1:0] p_s1;
			logic [RW-1:0]    q;
			logic [RW+MW-1:0] qm;
			logic [XW-1:0]    x_s2;
			logic [XW-1:0]    qm_s2;
			logic [XW-1:0]    r;
			logic [XW-1:0]    rc;

			assign q  = p_s1[XW+RW-1:XW];
			assign qm = q * MW'(MAIN_WORDS);

			always_ff @(posedge clk) begin
				x_s1  <= word;
				p_s1  <= word * RW'(RECIP);
				x_s2  <= x_s1;
				qm_s2 <= qm[XW-1:0];
			end

			assign r   = x_s2 - qm_s2;
			assign rc  = (r >= XW'(MAIN_WORDS)) ? r - XW'(MAIN_WORDS) : r;
			assign idx = rc[AW-1:0];
		end
	endgenerate

endmodule

@@ rtl/sbr_checker.sv @@
// ============================================================================
// sbr_checker
// Port-level assertions for the system bus with reservations.
// ============================================================================
module sbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic        write_done,
	input logic        protect_fault,
	input logic [2:0]  device,
	input logic        breakpoint_hit,
	input logic        stopped,
	input logic        error_flag
);
	import sbr_pkg::*;

	// Only one access is in progress at a time.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(device))
		else $error("stalled result changed");

	// A conditional write that lost its reservation touches nothing.
	a_cond_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_done |-> !protect_fault && (read_data == 32'd0))
		else $error("failed conditional write reported activity");

	a_fault_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && protect_fault |-> error_flag && (device == DEV_MAIN))
		else $error("protection fault without sticky error");

	a_hit_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && breakpoint_hit |-> stopped)
		else $error("breakpoint hit without run-stop");

endmodule

bind system_bus_with_reservations sbr_checker u_sbr_checker (.*);
